@@ hdl/serial_bank_mapper_core_macros.svh @@
// Assertion macros for the serial bank mapper.
// No dependencies; each file that asserts includes this header.
`ifndef SERIAL_BANK_MAPPER_CORE_MACROS_SVH
`define SERIAL_BANK_MAPPER_CORE_MACROS_SVH

`ifndef SYNTH
// Clocked check, masked while reset is asserted.
`define SBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds through reset.
`define SBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBM_ASSERT(lbl, prop, msg)
`define SBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/sbm_pkg.sv @@
// Shared types, constants and wrap tables for the serial bank mapper.
// No dependencies.
package sbm_pkg;

  localparam int PRG_BANKS = 16;  // 2..16 program banks of 16 KiB
  localparam int CHR_UNITS = 64;  // 64 pattern units of 4 KiB; the 5-bit slot reaches only 32 of them

  localparam logic [4:0] SHIFT_INIT   = 5'h10;
  localparam logic [4:0] CONTROL_INIT = 5'h04;

  // address bits 14:13 pick the register that a fifth serial write loads
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // control bits 3:2: program banking
  localparam logic [1:0] PRG_32K_A     = 2'd0;
  localparam logic [1:0] PRG_32K_B     = 2'd1;
  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

  typedef enum logic [1:0] {
    MODE_WRITE    = 2'd0,
    MODE_PRG_READ = 2'd1,
    MODE_CHR_READ = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    LOAD_NONE    = 3'd0,
    LOAD_CONTROL = 3'd1,
    LOAD_CHR0    = 3'd2,
    LOAD_CHR1    = 3'd3,
    LOAD_PRG     = 3'd4
  } load_e;

  typedef logic [3:0] prg_wrap_t [16];
  typedef logic [4:0] chr_wrap_t [32];

  // slot -> slot modulo ROM size, resolved at elaboration
  function automatic prg_wrap_t build_prg_wrap();
    prg_wrap_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = 4'(i % PRG_BANKS);
    end
    return t;
  endfunction

  function automatic chr_wrap_t build_chr_wrap();
    chr_wrap_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 5'(i % CHR_UNITS);
    end
    return t;
  endfunction

  localparam prg_wrap_t PRG_WRAP = build_prg_wrap();
  localparam chr_wrap_t CHR_WRAP = build_chr_wrap();

  localparam logic [3:0] PRG_LAST = 4'(PRG_BANKS - 1);

endpackage

@@ hdl/serial_bank_mapper_core.sv @@
// Serial bank mapper: five-write loader plus program/pattern address translation.
// Depends on sbm_pkg and serial_bank_mapper_core_macros.svh.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid_i in_ready_o mode_i address_i data_i | sink
//  out     | out_valid_o out_ready_i mapped_offset_o       | source
//          | hit_o loaded_register_o                      |
//
// One beat per cycle sustained while the result side is ready.
// The mapper registers update as a beat moves from the input register to the result register.
// Reset clears the loader to its marker, control to 4, banks to 0 and both valid flags.
// A stalled result freezes both stages; the input register still fills when it is empty.
`include "serial_bank_mapper_core_macros.svh"

module serial_bank_mapper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] mapped_offset_o,
  output logic        hit_o,
  output logic [2:0]  loaded_register_o
);
  import sbm_pkg::*;

  // input register
  logic        in_valid_q;
  mode_e       mode_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;

  // result register
  logic        out_valid_q;
  logic [17:0] offset_q, offset_d;
  logic        hit_q, hit_d;
  load_e       loaded_q, loaded_d;

  // mapper state
  logic [4:0] shift_q, shift_d;
  logic [4:0] control_q, control_d;
  logic [4:0] chr_a_q, chr_a_d;
  logic [4:0] chr_b_q, chr_b_d;
  logic [4:0] prg_q, prg_d;

  logic       adv;
  logic       step;
  logic [3:0] prg_low, prg_high, prg_slot;
  logic [4:0] chr_low, chr_high, chr_slot;
  logic [4:0] shift_next;

  assign adv        = !out_valid_q || out_ready_i;
  assign step       = adv && in_valid_q;
  assign in_ready_o = adv || !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q <= mode_e'(mode_i);
      addr_q <= address_i;
      data_q <= data_i;
    end
  end

  // slot banks follow directly from control and bank registers
  always_comb begin
    unique case (control_q[3:2])
      PRG_32K_A, PRG_32K_B: begin
        prg_low  = {prg_q[3:1], 1'b0};
        prg_high = {prg_q[3:1], 1'b1};
      end
      PRG_FIX_FIRST: begin
        prg_low  = 4'd0;
        prg_high = prg_q[3:0];
      end
      default: begin
        prg_low  = prg_q[3:0];
        prg_high = PRG_LAST;
      end
    endcase
    if (control_q[4]) begin
      chr_low  = chr_a_q;
      chr_high = chr_b_q;
    end else begin
      chr_low  = {chr_a_q[4:1], 1'b0};
      chr_high = {chr_a_q[4:1], 1'b1};
    end
  end

  assign prg_slot   = addr_q[14] ? prg_high : prg_low;
  assign chr_slot   = addr_q[12] ? chr_high : chr_low;
  assign shift_next = {data_q[0], shift_q[4:1]};

  always_comb begin
    shift_d   = shift_q;
    control_d = control_q;
    chr_a_d   = chr_a_q;
    chr_b_d   = chr_b_q;
    prg_d     = prg_q;
    offset_d  = '0;
    hit_d     = 1'b0;
    loaded_d  = LOAD_NONE;
    unique case (mode_q)
      MODE_WRITE: begin
        if (addr_q[15]) begin
          hit_d = 1'b1;
          if (data_q[7]) begin
            shift_d = SHIFT_INIT;
          end else if (shift_q[0]) begin
            // fifth bit: marker has reached bit 0
            shift_d = SHIFT_INIT;
            unique case (addr_q[14:13])
              SEL_CONTROL: begin
                control_d = shift_next;
                loaded_d  = LOAD_CONTROL;
              end
              SEL_CHR0: begin
                chr_a_d  = shift_next;
                loaded_d = LOAD_CHR0;
              end
              SEL_CHR1: begin
                chr_b_d  = shift_next;
                loaded_d = LOAD_CHR1;
              end
              default: begin
                prg_d    = shift_next;
                loaded_d = LOAD_PRG;
              end
            endcase
          end else begin
            shift_d = shift_next;
          end
        end
      end
      MODE_PRG_READ: begin
        if (addr_q[15]) begin
          hit_d    = 1'b1;
          offset_d = {PRG_WRAP[prg_slot], addr_q[13:0]};
        end
      end
      MODE_CHR_READ: begin
        if (addr_q[15:13] == 3'd0) begin
          hit_d    = 1'b1;
          offset_d = {1'b0, CHR_WRAP[chr_slot], addr_q[11:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      shift_q     <= SHIFT_INIT;
      control_q   <= CONTROL_INIT;
      chr_a_q     <= '0;
      chr_b_q     <= '0;
      prg_q       <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        shift_q   <= shift_d;
        control_q <= control_d;
        chr_a_q   <= chr_a_d;
        chr_b_q   <= chr_b_d;
        prg_q     <= prg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      offset_q <= offset_d;
      hit_q    <= hit_d;
      loaded_q <= loaded_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mapped_offset_o   = offset_q;
  assign hit_o             = hit_q;
  assign loaded_register_o = loaded_q;

  // loader state is only meaningful once reset has reached it
  `SBM_ASSERT_ALWAYS(a_marker_kept, !rst_ni || shift_q != 5'd0, "loader lost its marker bit")
  `SBM_ASSERT(a_load_clears, step && loaded_d != LOAD_NONE |=> shift_q == SHIFT_INIT, "no clear")
  `SBM_ASSERT(a_load_hits, out_valid_q && loaded_q != LOAD_NONE |-> hit_q, "load without hit")
  `SBM_ASSERT(a_offset_hits, out_valid_q && offset_q != 18'd0 |-> hit_q, "offset without hit")
  `SBM_ASSERT(a_beat_moves, step |=> out_valid_q, "beat dropped between stages")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for serial_bank_mapper_core: serial loader, bank slots and ROM offsets.
// Depends on sbm_pkg and the RTL; predicts every beat in-line and checks results in order.
module tb;
  import sbm_pkg::*;

  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic [17:0] offset;
    logic        hit;
    load_e       loaded;
  } map_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_NONE;
  logic [15:0] address_i = '0;
  logic [7:0]  data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [17:0] mapped_offset_o;
  logic        hit_o;
  logic [2:0]  loaded_register_o;

  serial_bank_mapper_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .data_i            (data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .mapped_offset_o   (mapped_offset_o),
    .hit_o             (hit_o),
    .loaded_register_o (loaded_register_o)
  );

  // mapper state as the bench sees it
  logic [4:0] ldr_shift;
  logic [4:0] ctrl_q;
  logic [4:0] chr_a_q;
  logic [4:0] chr_b_q;
  logic [4:0] prg_q;
  logic [3:0] prg_win_lo;
  logic [3:0] prg_win_hi;
  logic [5:0] chr_win_lo;
  logic [5:0] chr_win_hi;

  map_result_t expected_maps[$];
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned n_beats;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_loads[5];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_mapper();
    ldr_shift  = SHIFT_INIT;
    ctrl_q     = CONTROL_INIT;
    chr_a_q    = '0;
    chr_b_q    = '0;
    prg_q      = '0;
    prg_win_lo = 4'd0;
    prg_win_hi = 4'd1;
    chr_win_lo = 6'd0;
    chr_win_hi = 6'd1;
  endfunction

  function automatic void update_windows();
    logic [3:0] bank;
    bank = prg_q[3:0];
    case (ctrl_q[3:2])
      PRG_32K_A, PRG_32K_B: begin
        prg_win_lo = {bank[3:1], 1'b0};
        prg_win_hi = {bank[3:1], 1'b1};
      end
      PRG_FIX_FIRST: begin
        prg_win_lo = 4'd0;
        prg_win_hi = bank;
      end
      default: begin
        prg_win_lo = bank;
        prg_win_hi = 4'(PRG_BANKS - 1);
      end
    endcase
    if (ctrl_q[4]) begin
      chr_win_lo = {1'b0, chr_a_q};
      chr_win_hi = {1'b0, chr_b_q};
    end else begin
      chr_win_lo = {1'b0, chr_a_q[4:1], 1'b0};
      chr_win_hi = {1'b0, chr_a_q[4:1], 1'b1};
    end
  endfunction

  // expected result of one access; advances the bench's mapper state
  function automatic map_result_t map_access(mode_e m, logic [15:0] a, logic [7:0] d);
    map_result_t r;
    logic [4:0]  next;
    int unsigned bank;
    r = '{offset: '0, hit: 1'b0, loaded: LOAD_NONE};
    case (m)
      MODE_WRITE: begin
        if (a[15]) begin
          r.hit = 1'b1;
          if (d[7]) begin
            ldr_shift = SHIFT_INIT;
          end else begin
            next = {d[0], ldr_shift[4:1]};
            if (ldr_shift[0]) begin
              case (a[14:13])
                SEL_CONTROL: begin ctrl_q = next; r.loaded = LOAD_CONTROL; end
                SEL_CHR0:    begin chr_a_q = next; r.loaded = LOAD_CHR0; end
                SEL_CHR1:    begin chr_b_q = next; r.loaded = LOAD_CHR1; end
                default:     begin prg_q = next; r.loaded = LOAD_PRG; end
              endcase
              ldr_shift = SHIFT_INIT;
              update_windows();
            end else begin
              ldr_shift = next;
            end
          end
        end
      end
      MODE_PRG_READ: begin
        if (a[15]) begin
          bank = a[14] ? prg_win_hi : prg_win_lo;
          r.hit = 1'b1;
          r.offset = 18'(((bank % PRG_BANKS) << 14) | a[13:0]);
        end
      end
      MODE_CHR_READ: begin
        if (a < 16'h2000) begin
          bank = a[12] ? chr_win_hi : chr_win_lo;
          r.hit = 1'b1;
          r.offset = 18'(((bank % CHR_UNITS) << 12) | a[11:0]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (n_errors < MAX_PRINTED)
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // called on a rising edge; returns on the edge at which the beat is taken
  task automatic send_access(mode_e m, logic [15:0] a, logic [7:0] d);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    address_i  <= a;
    data_i     <= d;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    expected_maps.push_back(map_access(m, a, d));
    n_beats++;
  endtask

  task automatic send_serial(logic [1:0] sel, logic bit_in);
    send_access(MODE_WRITE, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), bit_in});
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk_i);
  endtask

  // result side: ready pattern, hold-off countdown and in-order compare
  initial begin
    logic        fire;
    map_result_t got;
    map_result_t want;
    forever begin
      @(negedge clk_i);
      fire = (out_valid_o === 1'b1) && (out_ready_i === 1'b1);
      got = '{offset: mapped_offset_o, hit: hit_o, loaded: load_e'(loaded_register_o)};
      @(posedge clk_i);
      if (fire) begin
        if (expected_maps.size() == 0) begin
          report_mismatch("result with nothing pending", got, 0);
        end else begin
          want = expected_maps.pop_front();
          if (got.offset !== want.offset) report_mismatch("mapped_offset", got.offset, want.offset);
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.loaded !== want.loaded) report_mismatch("loaded_register", got.loaded, want.loaded);
          if (want.loaded <= LOAD_PRG) n_loads[want.loaded]++;
          n_checked++;
        end
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // reset-state windows, hits and misses in both spaces
    send_access(MODE_PRG_READ, 16'h8000, 8'h00);
    send_access(MODE_PRG_READ, 16'hFFFF, 8'hFF);
    send_access(MODE_PRG_READ, 16'h7FFF, 8'h00);
    send_access(MODE_CHR_READ, 16'h0000, 8'h00);
    send_access(MODE_CHR_READ, 16'h1FFF, 8'h00);
    send_access(MODE_CHR_READ, 16'h2000, 8'h00);
    send_access(MODE_NONE, 16'hFFFF, 8'hFF);
    // write below the window, then a loader reset write
    send_access(MODE_WRITE, 16'h0000, 8'h01);
    send_access(MODE_WRITE, 16'h8000, 8'h80);
    // a partial load aborted by a reset write, then a full control load of all ones
    send_serial(SEL_CONTROL, 1'b0);
    send_serial(SEL_CONTROL, 1'b0);
    send_access(MODE_WRITE, 16'hFFFF, 8'hFF);
    repeat (5) send_serial(SEL_CONTROL, 1'b1);
    // program bank 15, data bits above bit 0 set to show they are ignored
    send_access(MODE_WRITE, 16'hE000, 8'h7F);
    send_access(MODE_WRITE, 16'hFFFF, 8'h7F);
    send_access(MODE_WRITE, 16'hE001, 8'h7F);
    send_access(MODE_WRITE, 16'hF000, 8'h7F);
    send_access(MODE_WRITE, 16'hE000, 8'h7E);
    send_access(MODE_PRG_READ, 16'hC000, 8'h00);
    send_access(MODE_PRG_READ, 16'h8000, 8'h00);
    send_access(MODE_CHR_READ, 16'h1000, 8'h00);
    wait_drained();
  endtask

  task automatic send_read();
    case ($urandom_range(19))
      0: send_access(MODE_PRG_READ, {1'b0, 15'($urandom)}, 8'($urandom));
      1: send_access(MODE_CHR_READ, 16'($urandom_range(16'hFFFF, 16'h2000)), 8'($urandom));
      2, 3, 4, 5, 6, 7, 8, 9, 10:
        send_access(MODE_PRG_READ, {1'b1, 15'($urandom)}, 8'($urandom));
      default: send_access(MODE_CHR_READ, {3'b000, 13'($urandom)}, 8'($urandom));
    endcase
  endtask

  // mostly five-write loads with random content and random reads; some noise
  task automatic test_traffic(int unsigned n_items, int unsigned idle, int unsigned stall);
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0]  sel;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = n_beats + n_items;
    while (n_beats < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        sel = 2'($urandom);
        if ($urandom_range(3) == 0) send_access(MODE_WRITE, {1'b1, 15'($urandom)}, 8'h80 | 8'($urandom));
        for (int k = 0; k < 5; k++) begin
          if ($urandom_range(9) == 0) send_read();
          if ($urandom_range(29) == 0)
            send_access(MODE_WRITE, {1'b1, 15'($urandom)}, 8'h80 | 8'($urandom));
          send_serial(sel, 1'($urandom));
        end
      end else if (pick < 85) begin
        send_read();
      end else begin
        send_access(mode_e'($urandom_range(3)), 16'($urandom), 8'($urandom));
      end
    end
    wait_drained();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_input_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 300;
    for (int k = 0; k < 12; k++) begin
      send_serial(2'($urandom), 1'($urandom));
      send_read();
    end
    wait_drained();
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    n_beats   = 0;
    n_checked = 0;
    n_errors  = 0;
    foreach (n_loads[i]) n_loads[i] = 0;
    clear_mapper();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_traffic(350, 0, 0);
    test_traffic(350, 60, 0);
    test_input_backpressure();
    test_traffic(350, 0, 60);
    test_traffic(350, 11, 11);

    repeat (8) @(posedge clk_i);
    if (expected_maps.size() != 0) report_mismatch("results never seen", expected_maps.size(), 0);
    $display("Covered %0d beats and checked %0d results under four idle/stall mixes",
             n_beats, n_checked);
    $display("Loads seen: control %0d, chr0 %0d, chr1 %0d, prg %0d; mismatches %0d",
             n_loads[LOAD_CONTROL], n_loads[LOAD_CHR0], n_loads[LOAD_CHR1], n_loads[LOAD_PRG],
             n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
